// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the tag cache sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TTLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TTLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTLC_ASSERT_SAME(label, ante, cons, msg)
`define TTLC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/ttlc_pkg.sv -----
// Types and constants of the timestamp tolerant tag cache.
package ttlc_pkg;

    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int TOL_W       = 16;
    localparam int REC_W       = 64;
    localparam int CNT_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int SLOT_FIELD_W = 5;

    localparam logic [TOL_W-1:0] TOL_RESET       = 16'd1500;
    localparam logic [REC_W-1:0] USE_CLOCK_RESET = 64'd1;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT       = 3'd0,
        STAT_MISS      = 3'd1,
        STAT_IGNORED   = 3'd2,
        STAT_REFRESHED = 3'd3,
        STAT_FILLED    = 3'd4,
        STAT_REPLACED  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic finish;
    } dp_cmd_t;

endpackage

// ----- rtl/core/ttlc_req_if.sv -----
// Request channel: command, source identifier and frame time.
interface ttlc_req_if;
    import ttlc_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ID_W-1:0]   source_id;
    logic [TIME_W-1:0] time_ms;

    modport source (output valid, cmd, source_id, time_ms, input ready);
    modport sink   (input valid, cmd, source_id, time_ms, output ready);
endinterface

// ----- rtl/core/ttlc_rsp_if.sv -----
// Response channel: status, slot, entry time and lookup counters.
interface ttlc_rsp_if;
    import ttlc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TIME_W-1:0]       entry_time_ms;
    logic [CNT_W-1:0]        hit_total;
    logic [CNT_W-1:0]        miss_total;

    modport source (output valid, status, slot, entry_time_ms, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, status, slot, entry_time_ms, hit_total, miss_total,
                    output ready);
endinterface

// ----- rtl/core/timestamp_tolerant_lru_tag_cache.sv -----
// Top level of the timestamp tolerant LRU tag cache.
// Requests arrive on req (cmd, source_id, time_ms) and one response leaves on rsp
// for every request transfer (status, slot, entry_time_ms, hit_total, miss_total).
// A lookup finds the valid entry of the same source closest in time within the
// tolerance and stamps its recency; a store refreshes a close match, fills the
// first empty slot or replaces the least recently used one.
// The tolerance register is loaded through cfg_wr_en and cfg_wr_data; write it
// only while no request is in flight.
// From transfer to response a request passes the scan and finish states: the tag
// memory has one read port, so the scan reads one slot per cycle, then drains the
// last read, and the finish state writes back and loads the response register.
// A new request is taken only in the idle state after the previous one is finished,
// so the cache does not take a new request before it is through with the last one.
// If rsp stalls, the finished response waits in its register while the next request
// is taken and scanned; that request then holds before write back until rsp drains.
// Reset clears all valid bits, both counters, sets the use clock to one and loads
// the tolerance with 1500 ms; no clearing pass is needed.
module timestamp_tolerant_lru_tag_cache #(
    parameter int SLOTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ttlc_req_if.sink                   req,
    ttlc_rsp_if.source                 rsp,
    input  logic                       cfg_wr_en,
    input  logic [ttlc_pkg::TOL_W-1:0] cfg_wr_data
);
    import ttlc_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    dp_cmd_t          dp_cmd;
    logic [IDX_W-1:0] rd_addr;

    ttlc_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (dp_cmd),
        .rd_addr   (rd_addr)
    );

    ttlc_datapath #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .rd_addr       (rd_addr),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_cmd        (req.cmd),
        .in_source_id  (req.source_id),
        .in_time_ms    (req.time_ms),
        .status        (rsp.status),
        .slot          (rsp.slot),
        .entry_time_ms (rsp.entry_time_ms),
        .hit_total     (rsp.hit_total),
        .miss_total    (rsp.miss_total)
    );

endmodule

// ----- rtl/core/ttlc_datapath.sv -----
// Tag memory, scan trackers, counters and response register of the tag cache.
module ttlc_datapath #(
    parameter int SLOTS = 32,
    parameter int IDX_W = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ttlc_pkg::dp_cmd_t                cmd,
    input  logic [IDX_W-1:0]                 rd_addr,
    input  logic                             cfg_wr_en,
    input  logic [ttlc_pkg::TOL_W-1:0]       cfg_wr_data,
    input  logic                             in_cmd,
    input  logic [ttlc_pkg::ID_W-1:0]        in_source_id,
    input  logic [ttlc_pkg::TIME_W-1:0]      in_time_ms,
    output logic [ttlc_pkg::STATUS_W-1:0]    status,
    output logic [ttlc_pkg::SLOT_FIELD_W-1:0] slot,
    output logic [ttlc_pkg::TIME_W-1:0]      entry_time_ms,
    output logic [ttlc_pkg::CNT_W-1:0]       hit_total,
    output logic [ttlc_pkg::CNT_W-1:0]       miss_total
);
    import ttlc_pkg::*;

    logic [ID_W-1:0]   src_mem [SLOTS];
    logic [TIME_W-1:0] time_mem [SLOTS];
    logic [REC_W-1:0]  rec_mem [SLOTS];

    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [TOL_W-1:0]  tol_reg;
    logic [REC_W-1:0]  use_clock_reg, use_clock_next;
    logic [CNT_W-1:0]  hit_reg, hit_next;
    logic [CNT_W-1:0]  miss_reg, miss_next;

    logic              req_cmd_reg;
    logic [ID_W-1:0]   req_id_reg;
    logic [TIME_W-1:0] req_time_reg;

    logic              eval_en_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [ID_W-1:0]   rd_src_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [REC_W-1:0]  rd_rec_reg;

    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_dist_reg;
    logic [TIME_W-1:0] best_time_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              inv_found_reg;
    logic [IDX_W-1:0]  inv_idx_reg;
    logic [IDX_W-1:0]  lru_idx_reg;
    logic [REC_W-1:0]  lru_rec_reg;

    status_t           status_reg, status_next;
    logic [SLOT_FIELD_W-1:0] slot_reg, slot_next;
    logic [TIME_W-1:0] etime_reg, etime_next;

    logic [TIME_W-1:0] cur_gap;
    logic              near;
    logic              id_zero;
    logic              wr_en;
    logic [IDX_W-1:0]  dest_idx;
    logic [TIME_W-1:0] wr_time;
    logic [IDX_W+SLOT_FIELD_W-1:0] dest_ext;

    always_comb
    begin
        cur_gap = (rd_time_reg >= req_time_reg) ? (rd_time_reg - req_time_reg)
                                                : (req_time_reg - rd_time_reg);
        near = valid_reg[eval_idx_reg] && (rd_src_reg == req_id_reg)
               && (cur_gap <= {{(TIME_W-TOL_W){1'b0}}, tol_reg});
    end

    // Decide the outcome once the scan is complete.
    always_comb
    begin
        id_zero        = (req_id_reg == '0);
        wr_en          = 1'b0;
        dest_idx       = '0;
        wr_time        = req_time_reg;
        status_next    = STAT_IGNORED;
        etime_next     = '0;
        use_clock_next = use_clock_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        valid_next     = valid_reg;
        if (!id_zero)
        begin
            if (req_cmd_reg == CMD_LOOKUP)
            begin
                if (best_found_reg)
                begin
                    wr_en          = 1'b1;
                    dest_idx       = best_idx_reg;
                    wr_time        = best_time_reg;
                    status_next    = STAT_HIT;
                    etime_next     = best_time_reg;
                    use_clock_next = use_clock_reg + 1'b1;
                    hit_next       = hit_reg + 1'b1;
                end
                else
                begin
                    status_next = STAT_MISS;
                    miss_next   = miss_reg + 1'b1;
                end
            end
            else
            begin
                wr_en          = 1'b1;
                etime_next     = req_time_reg;
                use_clock_next = use_clock_reg + 1'b1;
                if (match_found_reg)
                begin
                    dest_idx    = match_idx_reg;
                    status_next = STAT_REFRESHED;
                end
                else if (inv_found_reg)
                begin
                    dest_idx    = inv_idx_reg;
                    status_next = STAT_FILLED;
                end
                else
                begin
                    dest_idx    = lru_idx_reg;
                    status_next = STAT_REPLACED;
                end
            end
        end
        if (wr_en)
        begin
            valid_next[dest_idx] = 1'b1;
        end
        dest_ext  = {{SLOT_FIELD_W{1'b0}}, dest_idx};
        slot_next = wr_en ? dest_ext[SLOT_FIELD_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && wr_en)
        begin
            src_mem[dest_idx]  <= req_id_reg;
            time_mem[dest_idx] <= wr_time;
            rec_mem[dest_idx]  <= use_clock_reg;
        end
        if (cmd.rd_en)
        begin
            rd_src_reg  <= src_mem[rd_addr];
            rd_time_reg <= time_mem[rd_addr];
            rd_rec_reg  <= rec_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_cmd_reg  <= in_cmd;
            req_id_reg   <= in_source_id;
            req_time_reg <= in_time_ms;
        end
        eval_idx_reg <= rd_addr;
        if (eval_en_reg)
        begin
            if (near && (!best_found_reg || cur_gap < best_dist_reg))
            begin
                best_idx_reg  <= eval_idx_reg;
                best_dist_reg <= cur_gap;
                best_time_reg <= rd_time_reg;
            end
            if (near && !match_found_reg)
            begin
                match_idx_reg <= eval_idx_reg;
            end
            if (!valid_reg[eval_idx_reg] && !inv_found_reg)
            begin
                inv_idx_reg <= eval_idx_reg;
            end
            if (eval_idx_reg == '0 || rd_rec_reg < lru_rec_reg)
            begin
                lru_idx_reg <= eval_idx_reg;
                lru_rec_reg <= rd_rec_reg;
            end
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            etime_reg  <= etime_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            tol_reg         <= TOL_RESET;
            use_clock_reg   <= USE_CLOCK_RESET;
            hit_reg         <= '0;
            miss_reg        <= '0;
            eval_en_reg     <= 1'b0;
            best_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            inv_found_reg   <= 1'b0;
        end
        else
        begin
            eval_en_reg <= cmd.rd_en;
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                best_found_reg  <= 1'b0;
                match_found_reg <= 1'b0;
                inv_found_reg   <= 1'b0;
            end
            else if (eval_en_reg)
            begin
                if (near)
                begin
                    best_found_reg  <= 1'b1;
                    match_found_reg <= 1'b1;
                end
                if (!valid_reg[eval_idx_reg])
                begin
                    inv_found_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                valid_reg     <= valid_next;
                use_clock_reg <= use_clock_next;
                hit_reg       <= hit_next;
                miss_reg      <= miss_next;
            end
        end
    end

    assign status        = status_reg;
    assign slot          = slot_reg;
    assign entry_time_ms = etime_reg;
    assign hit_total     = hit_reg;
    assign miss_total    = miss_reg;

endmodule

// ----- rtl/core/ttlc_ctrl.sv -----
// Sequencer of the tag cache: accept, scan every slot, finish into the response register.
`include "assert_macros.svh"
module ttlc_ctrl #(
    parameter int SLOTS = 32,
    parameter int IDX_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ttlc_pkg::dp_cmd_t cmd,
    output logic [IDX_W-1:0]  rd_addr
);
    import ttlc_pkg::*;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(SLOTS);

    state_t           state_reg, state_next;
    logic [IDX_W:0]   cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
                cnt_next  = '0;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Read data is registered before evaluation; a last step drains it.
                cmd.rd_en = (cnt_reg < SCAN_END);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_END)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = !out_valid_reg || out_ready;
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign out_valid = out_valid_reg;

    `TTLC_ASSERT_SAME(a_finish_room, cmd.finish, !out_valid_reg || out_ready, "finish with response register full")
    `TTLC_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_reg, "response not presented after finish")
    `TTLC_ASSERT_NEXT(a_start_scan, cmd.start, state_reg == ST_SCAN && cnt_reg == '0, "scan did not begin after transfer")
    `TTLC_ASSERT_SAME(a_read_in_scan, cmd.rd_en, state_reg == ST_SCAN && !cmd.start && !cmd.finish, "read outside scan")

endmodule

// ----- tb/timestamp_tolerant_lru_tag_cache_checker.sv -----
// Checker for the timestamp tolerant LRU tag cache: predicts every response and compares it.
module timestamp_tolerant_lru_tag_cache_checker #(
    parameter int SLOTS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ttlc_req_if                        req,
    ttlc_rsp_if                        rsp,
    input  logic                       cfg_wr_en,
    input  logic [ttlc_pkg::TOL_W-1:0] cfg_wr_data,
    output int                         errors,
    output int                         outstanding,
    output int                         checked,
    output int                         hits,
    output int                         misses,
    output int                         ignores,
    output int                         refreshes,
    output int                         fills,
    output int                         replacements
);
    import ttlc_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [4:0]        slot;
        logic [TIME_W-1:0] entry_time;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
    } tag_response_t;

    tag_response_t owed_responses [$];

    logic              held_valid  [SLOTS];
    logic [ID_W-1:0]   held_source [SLOTS];
    logic [TIME_W-1:0] held_time   [SLOTS];
    logic [REC_W-1:0]  held_stamp  [SLOTS];
    logic [REC_W-1:0]  use_clock;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [TOL_W-1:0]  tolerance;

    int mismatch_count;
    int seen_count;
    int status_count [6];

    function automatic logic [TIME_W-1:0] time_gap(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic predict_tag_access(input logic c, input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] t, output tag_response_t r);
        int i;
        int best;
        int dest;
        logic [TIME_W-1:0] best_dist;
        logic [TIME_W-1:0] gap;
        r = '0;
        best = -1;
        dest = -1;
        best_dist = '0;
        if (id == '0)
        begin
            r.status = STAT_IGNORED;
        end
        else if (c == CMD_LOOKUP)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (held_valid[i] && held_source[i] == id)
                begin
                    gap = time_gap(held_time[i], t);
                    if (gap <= tolerance && (best < 0 || gap < best_dist))
                    begin
                        best = i;
                        best_dist = gap;
                    end
                end
            end
            if (best >= 0)
            begin
                held_stamp[best] = use_clock;
                use_clock = use_clock + 1'b1;
                hit_count = hit_count + 1'b1;
                r.status = STAT_HIT;
                r.slot = best[4:0];
                r.entry_time = held_time[best];
            end
            else
            begin
                miss_count = miss_count + 1'b1;
                r.status = STAT_MISS;
            end
        end
        else
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                if (dest < 0 && held_valid[i] && held_source[i] == id
                    && time_gap(held_time[i], t) <= tolerance)
                    dest = i;
            end
            r.status = STAT_REFRESHED;
            if (dest < 0)
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (dest < 0 && !held_valid[i])
                        dest = i;
                end
                r.status = STAT_FILLED;
            end
            if (dest < 0)
            begin
                dest = 0;
                for (i = 1; i < SLOTS; i++)
                begin
                    if (held_stamp[i] < held_stamp[dest])
                        dest = i;
                end
                r.status = STAT_REPLACED;
            end
            held_source[dest] = id;
            held_time[dest] = t;
            held_stamp[dest] = use_clock;
            use_clock = use_clock + 1'b1;
            held_valid[dest] = 1'b1;
            r.slot = dest[4:0];
            r.entry_time = t;
        end
        r.hit_total = hit_count;
        r.miss_total = miss_count;
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tag_response_t fresh;
        tag_response_t oldest;
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                held_valid[i] = 1'b0;
                held_source[i] = '0;
                held_time[i] = '0;
                held_stamp[i] = '0;
            end
            use_clock = USE_CLOCK_RESET;
            hit_count = '0;
            miss_count = '0;
            tolerance = TOL_RESET;
            owed_responses.delete();
            mismatch_count = 0;
            seen_count = 0;
            for (i = 0; i < 6; i++)
                status_count[i] = 0;
        end
        else
        begin
            if (cfg_wr_en)
                tolerance = cfg_wr_data;
            if (rsp.valid && rsp.ready)
            begin
                seen_count++;
                if (owed_responses.size() == 0)
                begin
                    $display("%0t: response with none awaited, expected nothing, actual status %0d slot %0d",
                             $time, rsp.status, rsp.slot);
                    mismatch_count++;
                end
                else
                begin
                    oldest = owed_responses.pop_front();
                    status_count[oldest.status]++;
                    mismatch_count += field_differs("status", 32'(oldest.status), 32'(rsp.status));
                    mismatch_count += field_differs("slot", 32'(oldest.slot), 32'(rsp.slot));
                    mismatch_count += field_differs("entry_time_ms", oldest.entry_time,
                                                    rsp.entry_time_ms);
                    mismatch_count += field_differs("hit_total", oldest.hit_total, rsp.hit_total);
                    mismatch_count += field_differs("miss_total", oldest.miss_total, rsp.miss_total);
                end
            end
            if (req.valid && req.ready)
            begin
                predict_tag_access(req.cmd, req.source_id, req.time_ms, fresh);
                owed_responses.push_back(fresh);
            end
        end
        errors       <= mismatch_count;
        outstanding  <= owed_responses.size();
        checked      <= seen_count;
        hits         <= status_count[STAT_HIT];
        misses       <= status_count[STAT_MISS];
        ignores      <= status_count[STAT_IGNORED];
        refreshes    <= status_count[STAT_REFRESHED];
        fills        <= status_count[STAT_FILLED];
        replacements <= status_count[STAT_REPLACED];
    end

endmodule

// ----- tb/timestamp_tolerant_lru_tag_cache_test.sv -----
// Regression bench for the timestamp tolerant LRU tag cache: stimulus, stalls and verdict.
module timestamp_tolerant_lru_tag_cache_test;
    import ttlc_pkg::*;

    localparam int SLOTS        = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = SLOTS + 12;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 5;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [TOL_W-1:0] cfg_wr_data;

    int errors;
    int outstanding;
    int checked;
    int hits;
    int misses;
    int ignores;
    int refreshes;
    int fills;
    int replacements;
    int cycles;

    bit                quiet_phase;
    logic [TOL_W-1:0]  tol_now;
    logic [ID_W-1:0]   id_pool     [8];
    logic [TIME_W-1:0] anchor_pool [4];
    logic [TOL_W-1:0]  tol_plan    [PHASES];

    ttlc_req_if req ();
    ttlc_rsp_if rsp ();

    timestamp_tolerant_lru_tag_cache #(
        .SLOTS(SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    timestamp_tolerant_lru_tag_cache_checker #(
        .SLOTS(SLOTS)
    ) tag_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .hits        (hits),
        .misses      (misses),
        .ignores     (ignores),
        .refreshes   (refreshes),
        .fills       (fills),
        .replacements(replacements)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic send_request(input logic c, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] t);
        int gap;
        req.valid <= 1'b1;
        req.cmd <= c;
        req.source_id <= id;
        req.time_ms <= t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        gap = idle_span();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the request side until every response has come back
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        int i;
        logic [TIME_W-1:0] span;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        tol_now = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        span = 32'(v) * 3 + 8;
        id_pool[0] = 32'd1;
        id_pool[1] = 32'd2;
        id_pool[2] = 32'd3;
        id_pool[3] = 32'hFFFF_FFFF;
        id_pool[4] = 32'h8000_0000;
        for (i = 5; i < 8; i++)
            id_pool[i] = $urandom | 32'd1;
        anchor_pool[0] = '0;
        anchor_pool[1] = 32'hFFFF_FFFF - span;
        anchor_pool[2] = $urandom >> 1;
        anchor_pool[3] = $urandom >> 1;
    endtask

    task automatic send_shaped();
        int r;
        logic c;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] span;
        r = $urandom_range(0, 99);
        c = 1'($urandom_range(0, 1));
        span = 32'(tol_now) * 3 + 8;
        if (r < 6)
        begin
            id = '0;
            t = $urandom;
        end
        else if (r < 14)
        begin
            id = $urandom;
            t = $urandom;
        end
        else
        begin
            id = id_pool[$urandom_range(0, 7)];
            t = anchor_pool[$urandom_range(0, 3)] + $urandom_range(0, span);
        end
        send_request(c, id, t);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                stall = idle_span();
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timestamp_tolerant_lru_tag_cache regression: fail");
        $finish;
    end

    initial
    begin
        int p;
        int n;
        req.valid <= 1'b0;
        req.cmd <= CMD_LOOKUP;
        req.source_id <= '0;
        req.time_ms <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        rst_n <= 1'b0;
        quiet_phase = 1'b0;
        tol_now = TOL_RESET;
        tol_plan[0] = 16'd0;
        tol_plan[1] = 16'hFFFF;
        tol_plan[2] = 16'd40;
        tol_plan[3] = 16'($urandom);
        tol_plan[4] = TOL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_LOOKUP, 32'd1, 32'd0);
        send_request(CMD_STORE, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_LOOKUP, 32'd0, 32'd0);
        send_request(CMD_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_STORE, 32'd1, 32'd0);
        send_request(CMD_LOOKUP, 32'd1, 32'd1500);
        send_request(CMD_LOOKUP, 32'd1, 32'd1501);
        send_request(CMD_STORE, 32'd1, 32'd1000);
        send_request(CMD_STORE, 32'd1, 32'd5000);
        send_request(CMD_STORE, 32'd1, 32'd4000);
        send_request(CMD_LOOKUP, 32'd1, 32'd2500);
        send_request(CMD_LOOKUP, 32'd1, 32'd2600);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF - 32'd1500);
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_LOOKUP, 32'd2, 32'd1000);
        send_request(CMD_STORE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_LOOKUP, 32'h8000_0000, 32'h8000_05DC);
        send_request(CMD_STORE, 32'h5555_5555, 32'hAAAA_AAAA);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            set_tolerance(tol_plan[p]);
            quiet_phase = (p == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_shaped();
            settle();
        end
        quiet_phase = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d responses: %0d hits, %0d misses, %0d ignored empty ids",
                 checked, hits, misses, ignores);
        $display("stores: %0d refreshed, %0d filled, %0d replaced LRU, tolerance 0 to 65535",
                 refreshes, fills, replacements);
        if (errors == 0)
            $display("timestamp_tolerant_lru_tag_cache regression: pass");
        else
            $display("timestamp_tolerant_lru_tag_cache regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ttlc_pkg.sv
rtl/core/ttlc_req_if.sv
rtl/core/ttlc_rsp_if.sv
rtl/core/ttlc_datapath.sv
rtl/core/ttlc_ctrl.sv
rtl/core/timestamp_tolerant_lru_tag_cache.sv
tb/timestamp_tolerant_lru_tag_cache_checker.sv
tb/timestamp_tolerant_lru_tag_cache_test.sv
